// ----- rtl/lz77d_pkg.sv -----
`timescale 1ns / 1ps

package lz77d_pkg;

   // Default history window size in bytes.
   localparam int WINDOW_BYTES_DEF = 4096;

   // Stream format constants.
   localparam logic [7:0] TAG_BYTE  = 8'h10;
   localparam int         DIST_W    = 12;
   localparam int         LEN_W     = 5;
   localparam logic [4:0] LEN_BIAS  = 5'd3;

   // Status codes carried on each result word.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_TAG   = 2'd1;
   localparam logic [1:0] STAT_FAR   = 2'd2;
   localparam logic [1:0] STAT_TRUNC = 2'd3;

   // Parse position within the compressed stream.
   typedef enum logic [7:0] {
      PH_TAG  = 8'b0000_0001,
      PH_LEN0 = 8'b0000_0010,
      PH_LEN1 = 8'b0000_0100,
      PH_LEN2 = 8'b0000_1000,
      PH_BODY = 8'b0001_0000,
      PH_REF2 = 8'b0010_0000,
      PH_DONE = 8'b0100_0000,
      PH_HALT = 8'b1000_0000
   } phase_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      SQ_IDLE    = 4'b0001,
      SQ_DECODE  = 4'b0010,
      SQ_COPY_RD = 4'b0100,
      SQ_COPY_WR = 4'b1000
   } seq_type;

endpackage

// ----- rtl/lz77d_window.sv -----
`timescale 1ns / 1ps

module lz77d_window import lz77d_pkg::*; #(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
   localparam int AW = $clog2(WINDOW_BYTES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [WINDOW_BYTES];
   logic [7:0] rd_data_ff;

   // History write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lz77_type10_decompressor.sv -----
`timescale 1ns / 1ps
// A literal or status result word is registered from the DECODE state once its input byte is accepted;
// the first copied byte of a reference is registered after the DECODE, COPY_RD and COPY_WR states.
// Header, flag and first reference bytes each pass through IDLE and DECODE, as does a literal.
// A reference copies N bytes (3..18), each with one window read and one write.
// An output stall holds the block; the block takes one word at a time.
// Reset is synchronous and clears all control state; the window itself is not cleared.
module lz77_type10_decompressor import lz77d_pkg::*; #(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_start,
   input  logic       req_in_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_has_byte,
   output logic       rsp_out_run_last,
   output logic       rsp_out_stream_done,
   output logic [1:0] rsp_out_status
);

   localparam int AW = $clog2(WINDOW_BYTES);
   localparam logic [AW:0] PROD_MAX = (AW+1)'(WINDOW_BYTES);

   seq_type           state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [AW-1:0]     wpos_ff, wpos_in;
   logic [23:0]       remain_ff, remain_in;
   logic [AW:0]       produced_ff, produced_in;
   logic [7:0]        flags_ff, flags_in;
   logic [3:0]        flag_idx_ff, flag_idx_in;
   logic [7:0]        ref1_ff, ref1_in;
   logic [7:0]        byte_ff, byte_in;
   logic              end_ff, end_in;
   logic [LEN_W-1:0]  copy_left_ff, copy_left_in;
   logic [DIST_W-1:0] dist_ff, dist_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_has_ff, rsp_has_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_done_ff, rsp_done_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic              out_free;
   logic              emit_go;
   logic [7:0]        emit_data;
   logic [23:0]       rem_dec;
   logic              emit_done;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [7:0]        rd_data;
   logic [DIST_W-1:0] ref_dist;
   logic [LEN_W-1:0]  ref_len;
   logic              ref_far;

   // The output register can take a word when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Shared emit datapath: remaining count and window position step together.
   assign rem_dec   = remain_ff - 24'd1;
   assign emit_done = (rem_dec == 24'd0);

   // Reference fields and window-range check.
   assign ref_dist = {ref1_ff[3:0], byte_ff};
   assign ref_len  = {1'b0, ref1_ff[7:4]} + LEN_BIAS;
   assign ref_far  = ((AW+1)'(ref_dist) + (AW+1)'(1)) > produced_ff;

   // Copy source sits distance plus one bytes behind the write position.
   assign rd_en   = (state_ff == SQ_COPY_RD);
   assign rd_addr = wpos_ff - AW'(dist_ff) - AW'(1);

   lz77d_window #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_window (
      .clock   (clock),
      .wr_en   (emit_go),
      .wr_addr (wpos_ff),
      .wr_data (emit_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer and stream parser.
   always_comb begin
      logic      res_go;
      logic      go_copy;
      logic      is_last;
      phase_type ph_nx;
      logic [7:0] wd_byte;
      logic       wd_has;
      logic       wd_done;
      logic [1:0] wd_status;

      state_in      = state_ff;
      phase_in      = phase_ff;
      wpos_in       = wpos_ff;
      remain_in     = remain_ff;
      produced_in   = produced_ff;
      flags_in      = flags_ff;
      flag_idx_in   = flag_idx_ff;
      ref1_in       = ref1_ff;
      byte_in       = byte_ff;
      end_in        = end_ff;
      copy_left_in  = copy_left_ff;
      dist_in       = dist_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_status_in = rsp_status_ff;
      emit_go       = 1'b0;
      emit_data     = byte_ff;
      res_go        = 1'b0;
      go_copy       = 1'b0;
      is_last       = 1'b0;
      ph_nx         = phase_ff;
      wd_byte       = 8'd0;
      wd_has        = 1'b0;
      wd_done       = 1'b0;
      wd_status     = STAT_OK;

      case (state_ff)
         SQ_IDLE: begin
            if (req_valid) begin
               byte_in  = req_in_byte;
               end_in   = req_in_end;
               state_in = SQ_DECODE;
               // A start word drops any stream in progress.
               if (req_in_start) begin
                  phase_in    = PH_TAG;
                  remain_in   = '0;
                  produced_in = '0;
                  flags_in    = '0;
                  flag_idx_in = 4'd8;
                  ref1_in     = '0;
                  wpos_in     = '0;
               end
            end
         end

         SQ_DECODE: begin
            case (phase_ff)
               PH_TAG: begin
                  if (byte_ff == TAG_BYTE) begin
                     ph_nx = PH_LEN0;
                  end else begin
                     ph_nx     = PH_HALT;
                     res_go    = 1'b1;
                     wd_status = STAT_TAG;
                  end
               end
               PH_LEN0: begin
                  remain_in = {16'd0, byte_ff};
                  ph_nx     = PH_LEN1;
               end
               PH_LEN1: begin
                  remain_in = {8'd0, byte_ff, remain_ff[7:0]};
                  ph_nx     = PH_LEN2;
               end
               PH_LEN2: begin
                  remain_in = {byte_ff, remain_ff[15:0]};
                  if ({byte_ff, remain_ff[15:0]} == 24'd0) begin
                     ph_nx   = PH_DONE;
                     res_go  = 1'b1;
                     wd_done = 1'b1;
                  end else begin
                     ph_nx = PH_BODY;
                  end
               end
               PH_BODY: begin
                  if (flag_idx_ff[3]) begin
                     flags_in    = byte_ff;
                     flag_idx_in = 4'd0;
                  end else if (flags_ff[3'd7 - flag_idx_ff[2:0]]) begin
                     ref1_in = byte_ff;
                     ph_nx   = PH_REF2;
                  end else begin
                     // Literal byte.
                     flag_idx_in = flag_idx_ff + 4'd1;
                     res_go      = 1'b1;
                     wd_byte     = byte_ff;
                     wd_has      = 1'b1;
                     wd_done     = emit_done;
                     ph_nx       = emit_done ? PH_DONE : PH_BODY;
                  end
               end
               PH_REF2: begin
                  flag_idx_in = flag_idx_ff + 4'd1;
                  if (ref_far) begin
                     ph_nx     = PH_HALT;
                     res_go    = 1'b1;
                     wd_status = STAT_FAR;
                  end else begin
                     ph_nx        = PH_BODY;
                     go_copy      = 1'b1;
                     copy_left_in = ref_len;
                     dist_in      = ref_dist;
                  end
               end
               default: begin
                  ph_nx = phase_ff;
               end
            endcase

            // Input ending before the declared length marks the stream truncated.
            if (end_ff && !go_copy && ph_nx != PH_DONE && ph_nx != PH_HALT) begin
               ph_nx     = PH_HALT;
               res_go    = 1'b1;
               wd_status = STAT_TRUNC;
            end

            if (!res_go || out_free) begin
               phase_in = ph_nx;
               state_in = go_copy ? SQ_COPY_RD : SQ_IDLE;
               if (res_go) begin
                  rsp_valid_in  = 1'b1;
                  rsp_last_in   = 1'b1;
                  rsp_byte_in   = wd_byte;
                  rsp_has_in    = wd_has;
                  rsp_done_in   = wd_done;
                  rsp_status_in = wd_status;
                  emit_go       = wd_has;
               end
            end else begin
               // Hold everything until the output register frees up.
               remain_in   = remain_ff;
               flags_in    = flags_ff;
               flag_idx_in = flag_idx_ff;
               ref1_in     = ref1_ff;
            end
         end

         SQ_COPY_RD: begin
            state_in = SQ_COPY_WR;
         end

         SQ_COPY_WR: begin
            if (out_free) begin
               is_last       = (copy_left_ff == LEN_W'(1)) || emit_done;
               emit_go       = 1'b1;
               emit_data     = rd_data;
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = rd_data;
               rsp_has_in    = 1'b1;
               rsp_last_in   = is_last;
               rsp_done_in   = emit_done;
               rsp_status_in = (is_last && end_ff && !emit_done) ? STAT_TRUNC : STAT_OK;
               copy_left_in  = copy_left_ff - LEN_W'(1);
               state_in      = is_last ? SQ_IDLE : SQ_COPY_RD;
               if (emit_done) begin
                  phase_in = PH_DONE;
               end else if (is_last && end_ff) begin
                  phase_in = PH_HALT;
               end
            end
         end

         default: begin
            state_in = SQ_IDLE;
         end
      endcase

      // Every emitted byte advances the window and the length counters.
      if (emit_go) begin
         remain_in = rem_dec;
         wpos_in   = wpos_ff + AW'(1);
         if (produced_ff != PROD_MAX) begin
            produced_in = produced_ff + (AW+1)'(1);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_IDLE;
         phase_ff     <= PH_TAG;
         wpos_ff      <= '0;
         remain_ff    <= '0;
         produced_ff  <= '0;
         flags_ff     <= '0;
         flag_idx_ff  <= 4'd8;
         ref1_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         wpos_ff      <= wpos_in;
         remain_ff    <= remain_in;
         produced_ff  <= produced_in;
         flags_ff     <= flags_in;
         flag_idx_ff  <= flag_idx_in;
         ref1_ff      <= ref1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      end_ff        <= end_in;
      copy_left_ff  <= copy_left_in;
      dist_ff       <= dist_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall           = (state_ff != SQ_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_byte        = rsp_byte_ff;
   assign rsp_out_has_byte    = rsp_has_ff;
   assign rsp_out_run_last    = rsp_last_ff;
   assign rsp_out_stream_done = rsp_done_ff;
   assign rsp_out_status      = rsp_status_ff;

endmodule

// ----- rtl/lz77d_checker.sv -----
`timescale 1ns / 1ps

module lz77d_checker import lz77d_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_has_byte,
   input logic       rsp_out_run_last,
   input logic       rsp_out_stream_done,
   input logic [1:0] rsp_out_status
);

   // A stalled result word stays valid and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_status) && $stable(rsp_out_run_last))
      else $error("stalled result word changed");

   // Words are decoded one at a time: an accepted word closes the input.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted twice in a row");

   // A status-only word is always the last word of its input.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_has_byte |-> rsp_out_run_last && rsp_out_byte == 8'd0)
      else $error("status-only word not final or carries data");

   // Reaching the declared length is never an error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_stream_done |-> rsp_out_status == STAT_OK && rsp_out_run_last)
      else $error("stream done word with error status or not final");

endmodule

bind lz77_type10_decompressor lz77d_checker u_lz77d_checker (.*);
